[hw/rtl/pktd_pkg.sv]
// ----------------------------------------------------------------------------
// pktd_pkg: shared types and constants of the line command deframer
// Holds the phase and error codes, the result word layout and the hex decode.
// ----------------------------------------------------------------------------
`default_nettype none

package pktd_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned LenW     = 16;
	localparam int unsigned CmdCntW  = 16;
	localparam int unsigned PackCntW = 32;
	localparam int unsigned OutDataW = 56;

	// Length of an empty command: the four header digits alone.
	localparam logic [LenW-1:0] HeaderLen = 16'd4;

	// Parser phase, one-hot.
	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_BODY   = 4'b0010,
		PH_PACK   = 4'b0100,
		PH_ERROR  = 4'b1000
	} pktd_phase_t;

	// Sticky error codes.
	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_HEX   = 2'd1,
		ERR_SHORT = 2'd2,
		ERR_MAGIC = 2'd3
	} pktd_err_t;

	// Byte classes reported with every word.
	typedef enum logic [1:0] {
		CLS_LENGTH = 2'd0,
		CLS_BODY   = 2'd1,
		CLS_PACK   = 2'd2,
		CLS_ERROR  = 2'd3
	} pktd_class_t;

	// Result word; the last member sits in the lowest bits.
	typedef struct packed {
		pktd_err_t             error_kind;
		logic [PackCntW-1:0]   pack_total;
		logic [CmdCntW-1:0]    command_total;
		logic                  entered_pack;
		logic                  command_done;
		pktd_class_t           byte_class;
	} pktd_result_t;

	// Magic that opens the pack section.
	localparam logic [ByteW-1:0] PackMagic [4] = '{8'h50, 8'h41, 8'h43, 8'h4B};

	// Hex digit decode: bit 4 set marks a byte that is no hex digit.
	function automatic logic [4:0] hex_decode(input logic [ByteW-1:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			v = {1'b0, c[3:0] + 4'd9};
		end
		return v;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/pkt_line_command_deframer.sv]
// ----------------------------------------------------------------------------
// pkt_line_command_deframer: line-framed command stream deframer
// Parses four-digit hex length headers, skips command bodies, switches to the
// pack section on a flush header and checks the PACK magic.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while no word is stalled and returns one
// result word per byte, in the cycle after the byte is taken. All per-byte work is a
// single pass of shallow logic from the parser state to the result register,
// so a byte can follow in every cycle; the result register takes the next byte
// in the same cycle in which the previous word drains, and s_tready stays low
// while a word waits on m_tready. Framing errors are sticky until reset.
`default_nettype none

module pkt_line_command_deframer import pktd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// [7:0] data_byte
	input  wire logic [ByteW-1:0]     s_tdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// [1:0] byte_class, [2] command_done, [3] entered_pack,
	// [19:4] command_total, [51:20] pack_total, [53:52] error_kind, [55:54] zero
	output logic [OutDataW-1:0]       m_tdata
);

	pktd_result_t  result;
	logic          load;

	assign load = s_tvalid && s_tready;

	pktd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.data_byte (s_tdata),
		.result    (result)
	);

	pktd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_result (result),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

[hw/rtl/pktd_parse.sv]
// ----------------------------------------------------------------------------
// pktd_parse: per-byte framing state and result logic
// Holds the parser state and computes the result for the byte being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pktd_parse import pktd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire logic [ByteW-1:0]   data_byte,
	output pktd_result_t            result
);

	pktd_phase_t           phase_q, phase_d;
	logic [LenW-1:0]       accum_q, accum_d;
	logic [1:0]            digits_q, digits_d;
	logic [LenW-1:0]       body_left_q, body_left_d;
	logic [2:0]            magic_q, magic_d;
	logic [CmdCntW-1:0]    cmd_cnt_q, cmd_cnt_d;
	logic [PackCntW-1:0]   pack_cnt_q, pack_cnt_d;
	pktd_err_t             err_q, err_d;

	logic [4:0]            hex;
	logic [LenW-1:0]       len;
	logic [LenW-1:0]       body_dec;
	pktd_class_t           cls;
	logic                  done;
	logic                  entered;

	assign hex      = hex_decode(data_byte);
	assign len      = {accum_q[LenW-5:0], hex[3:0]};
	assign body_dec = (body_left_q != '0) ? body_left_q - LenW'(1) : '0;

	// Next state and result of the current byte.
	always_comb begin
		phase_d     = phase_q;
		accum_d     = accum_q;
		digits_d    = digits_q;
		body_left_d = body_left_q;
		magic_d     = magic_q;
		cmd_cnt_d   = cmd_cnt_q;
		pack_cnt_d  = pack_cnt_q;
		err_d       = err_q;
		cls         = CLS_ERROR;
		done        = 1'b0;
		entered     = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				if (hex[4]) begin
					err_d   = ERR_HEX;
					phase_d = PH_ERROR;
				end else if (digits_q != 2'd3) begin
					accum_d  = len;
					digits_d = digits_q + 2'd1;
					cls      = CLS_LENGTH;
				end else begin
					accum_d  = '0;
					digits_d = '0;
					if (len == '0) begin
						phase_d = PH_PACK;
						magic_d = '0;
						entered = 1'b1;
						cls     = CLS_LENGTH;
					end else if (len < HeaderLen) begin
						err_d   = ERR_SHORT;
						phase_d = PH_ERROR;
					end else if (len == HeaderLen) begin
						if (cmd_cnt_q != '1) cmd_cnt_d = cmd_cnt_q + CmdCntW'(1);
						done = 1'b1;
						cls  = CLS_LENGTH;
					end else begin
						body_left_d = len - HeaderLen;
						phase_d     = PH_BODY;
						cls         = CLS_LENGTH;
					end
				end
			end
			PH_BODY: begin
				cls         = CLS_BODY;
				body_left_d = body_dec;
				if (body_dec == '0) begin
					if (cmd_cnt_q != '1) cmd_cnt_d = cmd_cnt_q + CmdCntW'(1);
					done     = 1'b1;
					phase_d  = PH_HEADER;
					digits_d = '0;
					accum_d  = '0;
				end
			end
			PH_PACK: begin
				if (magic_q[2] || data_byte == PackMagic[magic_q[1:0]]) begin
					if (!magic_q[2]) magic_d = magic_q + 3'd1;
					cls = CLS_PACK;
					if (pack_cnt_q != '1) pack_cnt_d = pack_cnt_q + PackCntW'(1);
				end else begin
					err_d   = ERR_MAGIC;
					phase_d = PH_ERROR;
				end
			end
			PH_ERROR: begin
				cls = CLS_ERROR;
			end
			default: begin
				cls = CLS_ERROR;
			end
		endcase
	end

	// The result carries the totals after this byte.
	always_comb begin
		result.byte_class    = cls;
		result.command_done  = done;
		result.entered_pack  = entered;
		result.command_total = cmd_cnt_d;
		result.pack_total    = pack_cnt_d;
		result.error_kind    = err_d;
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			accum_q     <= '0;
			digits_q    <= '0;
			body_left_q <= '0;
			magic_q     <= '0;
			cmd_cnt_q   <= '0;
			pack_cnt_q  <= '0;
			err_q       <= ERR_NONE;
		end else if (load) begin
			phase_q     <= phase_d;
			accum_q     <= accum_d;
			digits_q    <= digits_d;
			body_left_q <= body_left_d;
			magic_q     <= magic_d;
			cmd_cnt_q   <= cmd_cnt_d;
			pack_cnt_q  <= pack_cnt_d;
			err_q       <= err_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/pktd_out_reg.sv]
// ----------------------------------------------------------------------------
// pktd_out_reg: result register of the deframer
// Holds one result word; the input waits while that word is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module pktd_out_reg import pktd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire pktd_result_t         in_result,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [OutDataW-1:0]       m_tdata
);

	logic          valid_q;
	pktd_result_t  result_q;

	// A new word may enter when the register is empty or drains this cycle.
	assign in_ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			result_q <= in_result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(OutDataW - $bits(pktd_result_t)){1'b0}}, result_q};

endmodule

`default_nettype wire

[hw/rtl/pktd_checker.sv]
// ----------------------------------------------------------------------------
// pktd_checker: port-level assertions for the deframer
// Watches the stream ports and checks output register and sticky error rules.
// ----------------------------------------------------------------------------
`default_nettype none

module pktd_checker import pktd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic [ByteW-1:0]     s_tdata,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [OutDataW-1:0]  m_tdata
);

	logic       out_acc;
	logic [1:0] err_seen_q;

	assign out_acc = m_tvalid && m_tready;

	// Last error code shown on the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 2'd0;
		end else if (out_acc) begin
			err_seen_q <= m_tdata[53:52];
		end
	end

	// A waiting input word is held by the sender.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("input word changed while stalled");

	// A stalled word holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// An empty result register always takes a byte.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty result register");

	// Once reported, an error stays and every later byte is in error.
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && err_seen_q != 2'd0 |->
			m_tdata[53:52] == err_seen_q && m_tdata[1:0] == CLS_ERROR)
		else $error("error code not sticky");

	// Command completion and pack entry come only with header or body bytes.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2] || m_tdata[3]) |->
			(m_tdata[1:0] == CLS_LENGTH || m_tdata[1:0] == CLS_BODY) &&
			m_tdata[53:52] == ERR_NONE)
		else $error("completion flag on a pack or error byte");

endmodule

bind pkt_line_command_deframer pktd_checker u_pktd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

[verif/pkt_line_command_deframer_test.sv]
// ----------------------------------------------------------------------------
// pkt_line_command_deframer_test: self-checking bench for the command deframer
// Streams length-framed commands, a flush and a pack section (or one of the
// framing faults) into the block. A built-in predictor follows every accepted
// byte, and each result word is checked field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkt_line_command_deframer_test;
	import pktd_pkg::*;

	// Ways the byte stream can end; only one fits a run, since errors are sticky.
	typedef enum int {
		END_BAD_HEX,
		END_SHORT_LEN,
		END_BAD_MAGIC,
		END_PACK
	} stream_end_t;

	localparam logic [31:0] PackTag   = "PACK";
	localparam int          TailQuiet = 150;
	localparam int          HoldStart = 400;
	localparam int          HoldLen   = 300;
	localparam int          ResW      = $bits(pktd_result_t);

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic [ByteW-1:0]    s_tdata  = '0;
	logic                m_tready = 1'b0;
	wire                 s_tready;
	wire                 m_tvalid;
	wire [OutDataW-1:0]  m_tdata;

	pkt_line_command_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Stimulus and expected words.
	logic [ByteW-1:0] pending_bytes[$];
	pktd_result_t     expected_words[$];
	int               total_items = 0;
	int               drain_at    = -1;
	int               bytes_sent  = 0;
	int               words_seen  = 0;
	int               mismatches  = 0;
	int               gap_left    = 0;
	int               stall_left  = 0;
	int               cycle_count = 0;
	logic             rx_hold     = 1'b0;

	// Predicted parser state.
	pktd_phase_t      parse_phase    = PH_HEADER;
	logic [LenW-1:0]  len_acc        = '0;
	logic [1:0]       digits_seen    = '0;
	logic [LenW-1:0]  body_remaining = '0;
	logic [2:0]       magic_idx      = '0;
	logic [15:0]      cmd_count      = '0;
	logic [31:0]      pack_count     = '0;
	pktd_err_t        err_state      = ERR_NONE;

	initial begin
		forever #1 clk = ~clk;
	end

	// Returns 1 and the nibble value when the byte is a hex digit.
	function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] n);
		n = 4'h0;
		if (c >= "0" && c <= "9") begin
			n = 4'(c - "0");
			return 1'b1;
		end
		if (c >= "a" && c <= "f") begin
			n = 4'(c - "a" + 8'd10);
			return 1'b1;
		end
		if (c >= "A" && c <= "F") begin
			n = 4'(c - "A" + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Hex digit for a nibble, letters in random case.
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return 8'h30 + {4'h0, n};
		end
		if ($urandom_range(0, 1) == 1) begin
			return 8'h61 + {4'h0, n} - 8'd10;
		end
		return 8'h41 + {4'h0, n} - 8'd10;
	endfunction

	function automatic logic [7:0] magic_byte(input int idx);
		return PackTag[31 - 8 * idx -: 8];
	endfunction

	// Idling is off in some windows and in the tail of the run.
	function automatic bit idling_allowed(input int n);
		return (n < total_items - TailQuiet) && ((n / 128) % 4 != 3);
	endfunction

	// Advances the predicted parser by one byte and returns the expected word.
	function automatic pktd_result_t deframe_byte(input logic [7:0] b);
		pktd_result_t r;
		logic [3:0]   nib;
		logic [15:0]  full_len;
		bit           magic_ok;
		r = '0;
		r.byte_class = CLS_ERROR;
		case (parse_phase)
			PH_HEADER: begin
				if (!hex_nibble(b, nib)) begin
					parse_phase = PH_ERROR;
					err_state = ERR_HEX;
				end else begin
					full_len = {len_acc[11:0], nib};
					len_acc = full_len;
					if (digits_seen != 2'd3) begin
						digits_seen++;
						r.byte_class = CLS_LENGTH;
					end else begin
						digits_seen = '0;
						len_acc = '0;
						if (full_len == '0) begin
							parse_phase = PH_PACK;
							magic_idx = '0;
							r.entered_pack = 1'b1;
							r.byte_class = CLS_LENGTH;
						end else if (full_len < HeaderLen) begin
							parse_phase = PH_ERROR;
							err_state = ERR_SHORT;
						end else if (full_len == HeaderLen) begin
							if (cmd_count != '1) cmd_count++;
							r.command_done = 1'b1;
							r.byte_class = CLS_LENGTH;
						end else begin
							body_remaining = full_len - HeaderLen;
							parse_phase = PH_BODY;
							r.byte_class = CLS_LENGTH;
						end
					end
				end
			end
			PH_BODY: begin
				r.byte_class = CLS_BODY;
				if (body_remaining != '0) body_remaining--;
				if (body_remaining == '0) begin
					if (cmd_count != '1) cmd_count++;
					r.command_done = 1'b1;
					parse_phase = PH_HEADER;
					digits_seen = '0;
					len_acc = '0;
				end
			end
			PH_PACK: begin
				magic_ok = 1'b1;
				if (magic_idx < 3'd4) begin
					if (b != magic_byte(int'(magic_idx))) magic_ok = 1'b0;
					else magic_idx++;
				end
				if (magic_ok) begin
					r.byte_class = CLS_PACK;
					if (pack_count != '1) pack_count++;
				end else begin
					parse_phase = PH_ERROR;
					err_state = ERR_MAGIC;
				end
			end
			default: begin
			end
		endcase
		r.command_total = cmd_count;
		r.pack_total = pack_count;
		r.error_kind = err_state;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Compares one result word with the oldest expected word.
	task automatic check_word(input logic [OutDataW-1:0] word);
		pktd_result_t got;
		pktd_result_t want;
		got = pktd_result_t'(word[ResW-1:0]);
		if (expected_words.size() == 0) begin
			$error("result word %h arrived with nothing expected", word);
			mismatches++;
			return;
		end
		want = expected_words.pop_front();
		check_field("byte_class", 32'(want.byte_class), 32'(got.byte_class));
		check_field("command_done", 32'(want.command_done), 32'(got.command_done));
		check_field("entered_pack", 32'(want.entered_pack), 32'(got.entered_pack));
		check_field("command_total", 32'(want.command_total), 32'(got.command_total));
		check_field("pack_total", want.pack_total, got.pack_total);
		check_field("error_kind", 32'(want.error_kind), 32'(got.error_kind));
		check_field("pad", '0, 32'(word[OutDataW-1:ResW]));
	endtask

	task automatic push_len(input logic [15:0] len);
		for (int i = 3; i >= 0; i--) begin
			pending_bytes.push_back(hex_char(len[4 * i +: 4]));
		end
	endtask

	task automatic push_random_bytes(input int n);
		repeat (n) pending_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// Sender: offers the pending bytes, with random gaps and one drain pause.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_words.push_back(deframe_byte(s_tdata));
				bytes_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (bytes_sent == drain_at && expected_words.size() != 0) begin
					s_tvalid <= 1'b0;
				end else if (pending_bytes.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (idling_allowed(bytes_sent) && $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(0, 11);
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_bytes.pop_front();
				end
			end
		end
	end

	// Long receiver hold-off, so that the block fills up and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_count <= 0;
			rx_hold <= 1'b0;
		end else begin
			cycle_count <= cycle_count + 1;
			rx_hold <= (cycle_count >= HoldStart) && (cycle_count < HoldStart + HoldLen);
		end
	end

	// Receiver: checks every accepted word and stalls in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_word(m_tdata);
				words_seen++;
			end
			if (rx_hold) begin
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idling_allowed(words_seen) && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 11);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Stimulus, reset and the end of the run.
	initial begin
		int          len;
		int          plain_bytes;
		int          big_at;
		int          cmd_idx;
		int          pick;
		int          pos;
		stream_end_t finish_kind;
		logic [7:0]  b;
		logic [3:0]  nib;

		// Directed: empty command, body bytes at both extremes.
		push_len(16'h0004);
		push_len(16'h0005);
		pending_bytes.push_back(8'h00);
		push_len(16'h0006);
		pending_bytes.push_back(8'hFF);
		pending_bytes.push_back(8'h80);
		push_len(16'h0008);
		pending_bytes.push_back(8'h55);
		pending_bytes.push_back(8'hAA);
		pending_bytes.push_back(8'h01);
		pending_bytes.push_back(8'h7F);
		drain_at = pending_bytes.size();

		// Random commands, mostly short, one longer than all the others.
		plain_bytes = 0;
		cmd_idx = 0;
		big_at = $urandom_range(3, 30);
		while (plain_bytes < 950 || cmd_idx <= big_at) begin
			if (cmd_idx == big_at) begin
				len = 16'h0140;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 80) len = $urandom_range(4, 20);
				else if (pick < 98) len = $urandom_range(21, 64);
				else len = $urandom_range(16'h100, 16'h13F);
			end
			plain_bytes += len;
			push_len(16'(len));
			push_random_bytes(len - 4);
			cmd_idx++;
		end

		// The end of the stream: a framing fault or the pack section.
		pick = $urandom_range(0, 7);
		finish_kind = (pick < 3) ? stream_end_t'(pick) : END_PACK;
		case (finish_kind)
			END_BAD_HEX: begin
				repeat ($urandom_range(0, 3)) pending_bytes.push_back(hex_char(4'($urandom)));
				do b = 8'($urandom_range(0, 255)); while (hex_nibble(b, nib));
				pending_bytes.push_back(b);
			end
			END_SHORT_LEN: begin
				push_len(16'($urandom_range(1, 3)));
			end
			END_BAD_MAGIC: begin
				push_len(16'h0000);
				pos = $urandom_range(0, 3);
				for (int i = 0; i < pos; i++) pending_bytes.push_back(magic_byte(i));
				do b = 8'($urandom_range(0, 255)); while (b == magic_byte(pos));
				pending_bytes.push_back(b);
			end
			default: begin
				push_len(16'h0000);
				for (int i = 0; i < 4; i++) pending_bytes.push_back(magic_byte(i));
				pending_bytes.push_back(8'h00);
				pending_bytes.push_back(8'hFF);
				push_random_bytes(400);
			end
		endcase
		// Bytes after a fault must all report the error state.
		if (finish_kind != END_PACK) push_random_bytes(20);
		total_items = pending_bytes.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_sent < total_items || expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("[pkt_line_command_deframer] OK");
		end else begin
			$display("[pkt_line_command_deframer] ERROR");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#20_000_000;
		$display("[pkt_line_command_deframer] ERROR");
		$finish;
	end

endmodule
